FILE: src/safr_pkg.sv
package safr_pkg;

  localparam int BUFFER_BYTES = 256;

  localparam int CFG_COUNT = 6;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_READ_CODE        = 3'd0,
    CFG_WRITE_CODE       = 3'd1,
    CFG_SYNC_CODE        = 3'd2,
    CFG_ACK_CODE         = 3'd3,
    CFG_READ_REPLY_CODE  = 3'd4,
    CFG_WRITE_REPLY_CODE = 3'd5
  } cfg_index_t;

  localparam logic [7:0] RESET_READ_CODE        = 8'd1;
  localparam logic [7:0] RESET_WRITE_CODE       = 8'd2;
  localparam logic [7:0] RESET_SYNC_CODE        = 8'd0;
  localparam logic [7:0] RESET_ACK_CODE         = 8'd3;
  localparam logic [7:0] RESET_READ_REPLY_CODE  = 8'd4;
  localparam logic [7:0] RESET_WRITE_REPLY_CODE = 8'd5;

  typedef struct packed {
    logic [7:0] read_code;
    logic [7:0] write_code;
    logic [7:0] sync_code;
    logic [7:0] ack_code;
    logic [7:0] read_reply_code;
    logic [7:0] write_reply_code;
  } codes_t;

  typedef enum logic [2:0] {
    PH_SYNC  = 3'd0,
    PH_LENL  = 3'd1,
    PH_LENH  = 3'd2,
    PH_ADDR0 = 3'd3,
    PH_ADDR1 = 3'd4,
    PH_ADDR2 = 3'd5,
    PH_ADDR3 = 3'd6,
    PH_DATA  = 3'd7
  } phase_t;

endpackage

FILE: src/safr_ifs.sv
interface safr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] read_word;

  modport source (output valid, output rx_byte, output read_word, input ready);
  modport sink (input valid, input rx_byte, input read_word, output ready);
endinterface

interface safr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic [31:0] read_address;
  logic        data_valid;
  logic [7:0]  data_index;
  logic [7:0]  data_byte;
  logic        commit;
  logic [31:0] frame_address;
  logic [15:0] frame_length;

  modport source (
    output valid, output tx_byte, output read_address, output data_valid,
    output data_index, output data_byte, output commit, output frame_address,
    output frame_length, input ready
  );
  modport sink (
    input valid, input tx_byte, input read_address, input data_valid,
    input data_index, input data_byte, input commit, input frame_address,
    input frame_length, output ready
  );
endinterface

interface safr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [safr_pkg::CFG_INDEX_W-1:0]  index;
  logic [7:0]                        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/safr_cfg_regs.sv
module safr_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  safr_cfg_if.sink          cfg,
  output safr_pkg::codes_t  codes
);

  safr_pkg::codes_t codes_reg;

  assign cfg.ready = 1'b1;
  assign codes = codes_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes_reg.read_code        <= safr_pkg::RESET_READ_CODE;
      codes_reg.write_code       <= safr_pkg::RESET_WRITE_CODE;
      codes_reg.sync_code        <= safr_pkg::RESET_SYNC_CODE;
      codes_reg.ack_code         <= safr_pkg::RESET_ACK_CODE;
      codes_reg.read_reply_code  <= safr_pkg::RESET_READ_REPLY_CODE;
      codes_reg.write_reply_code <= safr_pkg::RESET_WRITE_REPLY_CODE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        safr_pkg::CFG_READ_CODE:        codes_reg.read_code        <= cfg.data;
        safr_pkg::CFG_WRITE_CODE:       codes_reg.write_code       <= cfg.data;
        safr_pkg::CFG_SYNC_CODE:        codes_reg.sync_code        <= cfg.data;
        safr_pkg::CFG_ACK_CODE:         codes_reg.ack_code         <= cfg.data;
        safr_pkg::CFG_READ_REPLY_CODE:  codes_reg.read_reply_code  <= cfg.data;
        safr_pkg::CFG_WRITE_REPLY_CODE: codes_reg.write_reply_code <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/spi_register_access_framer.sv
// Slave side of a byte-wise register access framing protocol.
// Each request on item_in carries one byte received from the master and the
// register word at the read address that the previous result asked for.
// Each request produces exactly one result on item_out: the byte to shift
// back, the next read address, any write data byte with its index, a commit
// flag when a write frame ends by length, and the current frame address and
// length. The cfg channel writes the six command and reply codes; it is
// always ready and should only be used while the block is idle.
// The result of an accepted request is registered and shows on item_out in
// the cycle after it is accepted. Throughput is one request per cycle, set by
// the single result register that follows the phase logic. The next request is
// taken while a result is pending as long as item_out accepts it in the same
// cycle; when item_out stalls, the result holds and item_in is not ready.
// Reset returns the phase machine to idle, clears the frame state, drops
// the pending result and restores the default codes.
module spi_register_access_framer (
  input  logic        clk,
  input  logic        rst,
  safr_in_if.sink     item_in,
  safr_out_if.source  item_out,
  safr_cfg_if.sink    cfg
);

  safr_pkg::codes_t codes;

  safr_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .codes (codes)
  );

  safr_pkg::phase_t phase, phase_next;
  logic        is_read, is_read_next;
  logic [15:0] payload_length, payload_length_next;
  logic [31:0] target_address, target_address_next;
  logic [15:0] byte_index, byte_index_next;

  logic        out_valid;
  logic [7:0]  out_tx_byte;
  logic [31:0] out_read_address;
  logic        out_data_valid;
  logic [7:0]  out_data_index;
  logic [7:0]  out_data_byte;
  logic        out_commit;

  logic [7:0]  tx_next;
  logic [31:0] read_address_next;
  logic        data_valid_next;
  logic [7:0]  data_index_next;
  logic [7:0]  data_byte_next;
  logic        commit_next;

  logic        accept;
  logic [7:0]  rx;
  logic [15:0] index_inc;
  logic        by_length;
  logic        is_sync;

  assign rx = item_in.rx_byte;
  assign item_in.ready = !out_valid || item_out.ready;
  assign accept = item_in.valid && item_in.ready;

  assign index_inc = byte_index + 16'd1;
  assign by_length = {1'b0, index_inc} >= ({1'b0, payload_length} + 17'd1);
  assign is_sync = (rx == codes.sync_code);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      safr_pkg::PH_SYNC: begin
        if (rx == codes.read_code || rx == codes.write_code) begin
          phase_next = safr_pkg::PH_LENL;
        end
      end
      safr_pkg::PH_LENL:  phase_next = safr_pkg::PH_LENH;
      safr_pkg::PH_LENH:  phase_next = safr_pkg::PH_ADDR0;
      safr_pkg::PH_ADDR0: phase_next = safr_pkg::PH_ADDR1;
      safr_pkg::PH_ADDR1: phase_next = safr_pkg::PH_ADDR2;
      safr_pkg::PH_ADDR2: phase_next = safr_pkg::PH_ADDR3;
      safr_pkg::PH_ADDR3: phase_next = safr_pkg::PH_DATA;
      safr_pkg::PH_DATA: begin
        if (is_sync || by_length) begin
          phase_next = safr_pkg::PH_SYNC;
        end
      end
      default: phase_next = safr_pkg::PH_SYNC;
    endcase
  end

  always_comb begin
    is_read_next        = is_read;
    payload_length_next = payload_length;
    target_address_next = target_address;
    byte_index_next     = byte_index;
    tx_next             = codes.sync_code;
    data_valid_next     = 1'b0;
    data_index_next     = 8'd0;
    data_byte_next      = 8'd0;
    commit_next         = 1'b0;
    unique case (phase)
      safr_pkg::PH_SYNC: begin
        if (rx == codes.read_code || rx == codes.write_code) begin
          is_read_next = (rx == codes.read_code);
        end
      end
      safr_pkg::PH_LENL: begin
        payload_length_next = {8'd0, rx};
        tx_next = is_read ? codes.read_reply_code : codes.write_reply_code;
      end
      safr_pkg::PH_LENH: begin
        payload_length_next = {rx, payload_length[7:0]};
        tx_next = payload_length[7:0];
      end
      safr_pkg::PH_ADDR0: begin
        target_address_next = {24'd0, rx};
        tx_next = payload_length[15:8];
      end
      safr_pkg::PH_ADDR1: begin
        target_address_next = {target_address[31:16], rx, target_address[7:0]};
        tx_next = target_address[7:0];
      end
      safr_pkg::PH_ADDR2: begin
        target_address_next = {target_address[31:24], rx, target_address[15:0]};
        tx_next = target_address[15:8];
      end
      safr_pkg::PH_ADDR3: begin
        target_address_next = {rx, target_address[23:0]};
        byte_index_next = 16'd0;
        tx_next = target_address[23:16];
      end
      safr_pkg::PH_DATA: begin
        byte_index_next = index_inc;
        if (is_read) begin
          tx_next = item_in.read_word[{byte_index[1:0], 3'b000} +: 8];
        end else begin
          tx_next = codes.ack_code;
          if ({1'b0, byte_index} < 17'(safr_pkg::BUFFER_BYTES)) begin
            data_valid_next = 1'b1;
            data_index_next = byte_index[7:0];
            data_byte_next  = rx;
          end
          commit_next = by_length;
        end
        if (byte_index == 16'd0) begin
          tx_next = target_address[31:24];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (phase_next == safr_pkg::PH_DATA && is_read_next) begin
      read_address_next = target_address_next + {16'd0, byte_index_next[15:2], 2'b00};
    end else begin
      read_address_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= safr_pkg::PH_SYNC;
      is_read        <= 1'b0;
      payload_length <= 16'd0;
      target_address <= 32'd0;
      byte_index     <= 16'd0;
    end else if (accept) begin
      phase          <= phase_next;
      is_read        <= is_read_next;
      payload_length <= payload_length_next;
      target_address <= target_address_next;
      byte_index     <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (item_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tx_byte      <= tx_next;
      out_read_address <= read_address_next;
      out_data_valid   <= data_valid_next;
      out_data_index   <= data_index_next;
      out_data_byte    <= data_byte_next;
      out_commit       <= commit_next;
    end
  end

  assign item_out.valid         = out_valid;
  assign item_out.tx_byte       = out_tx_byte;
  assign item_out.read_address  = out_read_address;
  assign item_out.data_valid    = out_data_valid;
  assign item_out.data_index    = out_data_index;
  assign item_out.data_byte     = out_data_byte;
  assign item_out.commit        = out_commit;
  assign item_out.frame_address = target_address;
  assign item_out.frame_length  = payload_length;

  // A pending commit means the write frame has already closed.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_commit) |-> (phase == safr_pkg::PH_SYNC && !is_read))
    else $error("commit pending while a frame is still open");

  // Write data is only ever emitted by a write frame.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data_valid) |-> !is_read)
    else $error("write data emitted in a read frame");

  // A read address is only requested while a read frame is in its data phase.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_read_address != 32'd0)
      |-> (phase == safr_pkg::PH_DATA && is_read))
    else $error("read address outside the data phase of a read frame");

  // A stalled result blocks new requests.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !item_out.ready) |=> $stable(byte_index) && $stable(phase))
    else $error("frame state advanced while the result was stalled");

endmodule
